### rtl/core/idf_pkg.sv
// shared types, constants and helper functions of the impulse deglitch filter
package idf_pkg;

  localparam int DEF_MAX_COLS = 32;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int PIX_W      = 4;
  localparam int GLYPH_W    = 7;
  localparam int CFG_ROWS_W = 11;
  localparam int CFG_COLS_W = 6;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  localparam logic [CFG_ROWS_W-1:0] RESET_ROWS = 11'd20;
  localparam logic [CFG_COLS_W-1:0] RESET_COLS = 6'd30;

  localparam logic [PIX_W-1:0] LEVEL_MAX = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_CALC
  } idf_state_t;

  typedef struct packed {
    logic accept;
    logic issue_a;
    logic issue_b;
    logic issue_c;
    logic emit;
  } idf_cmd_t;

  typedef struct packed {
    logic emits_any;
    logic job_more;
    logic out_busy;
  } idf_status_t;

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [PIX_W-1:0] lv);
    logic [GLYPH_W-1:0] g;
    unique case (lv)
      4'd0:    g = 7'd32;
      4'd1:    g = 7'd46;
      4'd2:    g = 7'd39;
      4'd3:    g = 7'd58;
      4'd4:    g = 7'd126;
      4'd5:    g = 7'd42;
      4'd6:    g = 7'd61;
      4'd7:    g = 7'd38;
      4'd8:    g = 7'd37;
      default: g = 7'd35;
    endcase
    return g;
  endfunction

endpackage

### rtl/core/impulse_deglitch_filter.sv
// Impulse deglitch filter: top level joining sequencer and datapath.
// A word causes n results (n is 0..3); no new word is taken until all of them
// are emitted. Each result is read through states A, B and C, as the line store has
// two read ports, then filtered in calc, which waits while the output is held.
// Reset (synchronous, rst high): position to frame start, frame size 20 x 30,
// no word pending; the line store is not cleared.
module impulse_deglitch_filter #(
  parameter int MAX_COLS = idf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = idf_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [idf_pkg::PIX_W-1:0]      pixel,
  input  logic                           cfg_we,
  input  logic [idf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [idf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [$clog2(MAX_ROWS)-1:0]    out_row,
  output logic [$clog2(MAX_COLS)-1:0]    out_col,
  output logic [idf_pkg::PIX_W-1:0]      level,
  output logic [idf_pkg::GLYPH_W-1:0]    glyph,
  output logic                           frame_end,
  output logic                           run_end
);
  import idf_pkg::*;

  idf_cmd_t    cmd;
  idf_status_t status;

  idf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  idf_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .pixel     (pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .level     (level),
    .glyph     (glyph),
    .frame_end (frame_end),
    .run_end   (run_end)
  );

endmodule

### rtl/core/idf_ctrl.sv
// sequencer: accepts a word, then walks the memory reads and emits each result
module idf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  idf_pkg::idf_status_t status,
  output idf_pkg::idf_cmd_t    cmd
);
  import idf_pkg::*;

  idf_state_t state;
  idf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.emits_any) state_next = ST_RD_A;
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_RD_C;
      ST_RD_C: state_next = ST_CALC;
      ST_CALC: begin
        if (!status.out_busy) state_next = status.job_more ? ST_RD_A : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_RD_A: cmd.issue_a = 1'b1;
      ST_RD_B: cmd.issue_b = 1'b1;
      ST_RD_C: cmd.issue_c = 1'b1;
      ST_CALC: cmd.emit = !status.out_busy;
      default: ;
    endcase
  end

  // read data of each phase lands in the following state, from the registered read ports
  a_rd_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_A |=> state == ST_RD_B)
    else $error("read phases out of order");

  a_rd_to_calc: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_C |=> state == ST_CALC)
    else $error("right neighbour read not followed by calc");

  a_calc_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && status.out_busy) |=> state == ST_CALC)
    else $error("left calc while output word still held");

  a_no_result_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !status.emits_any) |=> state == ST_IDLE)
    else $error("word with no result started a read sequence");

endmodule

### rtl/core/idf_datapath.sv
// datapath: config registers, position counters, line store, filter and output register
module idf_datapath #(
  parameter int MAX_COLS = idf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = idf_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  idf_pkg::idf_cmd_t              cmd,
  output idf_pkg::idf_status_t           status,
  input  logic [idf_pkg::PIX_W-1:0]      pixel,
  input  logic                           cfg_we,
  input  logic [idf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [idf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [$clog2(MAX_ROWS)-1:0]    out_row,
  output logic [$clog2(MAX_COLS)-1:0]    out_col,
  output logic [idf_pkg::PIX_W-1:0]      level,
  output logic [idf_pkg::GLYPH_W-1:0]    glyph,
  output logic                           frame_end,
  output logic                           run_end
);
  import idf_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DEPTH  = 3 * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [1:0] mod_inc(input logic [1:0] m);
    return (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  function automatic logic [1:0] mod_dec(input logic [1:0] m);
    return (m == 2'd0) ? 2'd2 : m - 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] m,
                                                input logic [COL_W-1:0] c);
    return ADDR_W'(int'(m) * MAX_COLS + int'(c));
  endfunction

  function automatic logic near1(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] d;
    d = (a > v) ? a - v : v - a;
    return d <= 4'd1;
  endfunction

  // configuration and effective frame size
  logic [CFG_ROWS_W-1:0] frame_rows;
  logic [CFG_COLS_W-1:0] frame_cols;
  logic [ROW_W-1:0]      last_row;
  logic [COL_W-1:0]      last_col;
  logic                  cfg_hit;

  always_comb begin
    if (frame_rows < 11'd2) begin
      last_row = ROW_W'(1);
    end else if (int'(frame_rows) > MAX_ROWS) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(frame_rows - 11'd1);
    end
    if (frame_cols < 6'd2) begin
      last_col = COL_W'(1);
    end else if (int'(frame_cols) > MAX_COLS) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(frame_cols - 6'd1);
    end
  end

  always_comb begin
    unique case (cfg_index) inside
      REG_FRAME_ROWS, REG_FRAME_COLS: cfg_hit = cfg_we;
      default:                        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= RESET_ROWS;
      frame_cols <= RESET_COLS;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_ROWS) frame_rows <= cfg_data;
      if (cfg_index == REG_FRAME_COLS) frame_cols <= cfg_data[CFG_COLS_W-1:0];
    end
  end

  // position of the next input word, row modulo three selects the store row
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [1:0]       row_mod;
  logic             at_last_row;
  logic             at_last_col;
  logic [2:0]       emits;

  assign at_last_row = (row_count == last_row);
  assign at_last_col = (col_count == last_col);
  assign emits = {at_last_row && at_last_col,
                  at_last_row && (col_count != '0),
                  row_count != '0};

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_count <= '0;
      col_count <= '0;
      row_mod   <= 2'd0;
    end else if (cmd.accept) begin
      if (at_last_col) begin
        col_count <= '0;
        if (at_last_row) begin
          row_count <= '0;
          row_mod   <= 2'd0;
        end else begin
          row_count <= row_count + ROW_W'(1);
          row_mod   <= mod_inc(row_mod);
        end
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // pending results of the accepted word, oldest first
  logic [2:0]       pending;
  logic [2:0]       pending_after;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [1:0]       cur_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd.accept) begin
      pending <= emits;
    end else if (cmd.emit) begin
      pending <= pending_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_row <= row_count;
      cur_col <= col_count;
      cur_mod <= row_mod;
    end
  end

  // current job coordinates
  logic [ROW_W-1:0] job_row;
  logic [COL_W-1:0] job_col;
  logic [1:0]       job_mod;
  logic             has_up, has_dn, has_lf, has_rt;

  always_comb begin
    pending_after = pending;
    job_row = cur_row;
    job_col = cur_col;
    job_mod = cur_mod;
    if (pending[0]) begin
      pending_after[0] = 1'b0;
      job_row = cur_row - ROW_W'(1);
      job_mod = mod_dec(cur_mod);
    end else if (pending[1]) begin
      pending_after[1] = 1'b0;
      job_col = cur_col - COL_W'(1);
    end else begin
      pending_after[2] = 1'b0;
    end
  end

  assign has_up = (job_row != '0);
  assign has_dn = (job_row != last_row);
  assign has_lf = (job_col != '0);
  assign has_rt = (job_col != last_col);

  // line store: one write port, two registered read ports
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  pix_sat;
  logic [ADDR_W-1:0] rd_addr0, rd_addr1;
  logic [PIX_W-1:0]  rd0, rd1;
  logic              rd_en;

  assign pix_sat = (pixel > LEVEL_MAX) ? LEVEL_MAX : pixel;
  assign rd_en   = cmd.issue_a || cmd.issue_b || cmd.issue_c;

  always_comb begin
    if (cmd.issue_a) begin
      rd_addr0 = addr_of(job_mod, job_col);
      rd_addr1 = addr_of(mod_dec(job_mod), job_col);
    end else if (cmd.issue_b) begin
      rd_addr0 = addr_of(mod_inc(job_mod), job_col);
      rd_addr1 = addr_of(job_mod, job_col - COL_W'(1));
    end else begin
      rd_addr0 = addr_of(job_mod, job_col + COL_W'(1));
      rd_addr1 = addr_of(job_mod, job_col - COL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) mem[addr_of(row_mod, col_count)] <= pix_sat;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0 <= mem[rd_addr0];
      rd1 <= mem[rd_addr1];
    end
  end

  logic [PIX_W-1:0] cen, upv, dnv, lfv;

  always_ff @(posedge clk) begin
    if (cmd.issue_b) begin
      cen <= rd0;
      upv <= rd1;
    end
    if (cmd.issue_c) begin
      dnv <= rd0;
      lfv <= rd1;
    end
  end

  // keep the pixel if a neighbour is close, else rounded mean, ties to even
  logic [PIX_W-1:0] filt;

  always_comb begin
    logic       near;
    logic [5:0] sum;
    logic [2:0] cnt;
    logic [3:0] q;
    logic [9:0] prod;
    logic [5:0] rem3;
    logic       rnd;
    logic [3:0] mean;
    near = (has_up && near1(upv, cen)) || (has_dn && near1(dnv, cen)) ||
           (has_lf && near1(lfv, cen)) || (has_rt && near1(rd0, cen));
    sum = (has_up ? 6'(upv) : 6'd0) + (has_dn ? 6'(dnv) : 6'd0) +
          (has_lf ? 6'(lfv) : 6'd0) + (has_rt ? 6'(rd0) : 6'd0);
    cnt = 3'(has_up) + 3'(has_dn) + 3'(has_lf) + 3'(has_rt);
    prod = 10'(sum) * 10'd11;
    rem3 = 6'd0;
    case (cnt)
      3'd2: begin
        q   = sum[4:1];
        rnd = sum[0] && q[0];
      end
      3'd3: begin
        // sum stays below 28, so the reciprocal 11/32 gives the exact quotient
        q    = prod[8:5];
        rem3 = sum - (6'({q, 1'b0}) + 6'(q));
        rnd  = (rem3 == 6'd2);
      end
      3'd4: begin
        q   = sum[5:2];
        rnd = (sum[1:0] == 2'd3) || (sum[1:0] == 2'd2 && q[0]);
      end
      default: begin
        q   = cen;
        rnd = 1'b0;
      end
    endcase
    mean = q + 4'(rnd);
    filt = near ? cen : mean;
    if (filt > LEVEL_MAX) filt = LEVEL_MAX;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row   <= job_row;
      out_col   <= job_col;
      level     <= filt;
      glyph     <= glyph_of(filt);
      frame_end <= (job_row == last_row) && (job_col == last_col);
      run_end   <= (pending_after == '0);
    end
  end

  assign status.emits_any = |emits;
  assign status.job_more  = |pending_after;
  assign status.out_busy  = out_valid && !out_ready;

endmodule

### sim/tb.sv
// self-checking testbench of the impulse deglitch filter, with its own frame predictor
`timescale 1ns / 100ps

module tb;
  import idf_pkg::*;

  localparam int PIPE_SETTLE  = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int TOTAL_PIXELS = 410;
  localparam int CALM_FROM    = 350;
  localparam int SCRIPT_LEN   = 25;
  localparam int ROW_W        = $clog2(DEF_MAX_ROWS);
  localparam int COL_W        = $clog2(DEF_MAX_COLS);

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [PIX_W-1:0]   lvl;
    logic [GLYPH_W-1:0] gly;
    logic               fend;
    logic               rend;
  } filt_word_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      px;
    logic                  typed;
    logic [1:0]            n_typed;
  } script_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_valid;
  logic                  out_ready;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic [PIX_W-1:0]      level;
  logic [GLYPH_W-1:0]    glyph;
  logic                  frame_end;
  logic                  run_end;

  impulse_deglitch_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .level     (level),
    .glyph     (glyph),
    .frame_end (frame_end),
    .run_end   (run_end)
  );

  // directed start: checkerboard frames invert, levels above nine, half-even mean,
  // then a 3x3 frame with a lone spike in the centre
  script_row_t script [0:SCRIPT_LEN-1] = '{
    '{1'b1, REG_FRAME_ROWS, 11'd0,    4'd0,  1'b0, 2'd0},
    '{1'b1, REG_FRAME_COLS, 11'd1,    4'd0,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd0,  1'b1, 2'd0},
    '{1'b0, '0,             11'd0,    4'd9,  1'b1, 2'd0},
    '{1'b0, '0,             11'd0,    4'd9,  1'b1, 2'd1},
    '{1'b0, '0,             11'd0,    4'd0,  1'b1, 2'd3},
    '{1'b0, '0,             11'd0,    4'd15, 1'b1, 2'd0},
    '{1'b0, '0,             11'd0,    4'd0,  1'b1, 2'd0},
    '{1'b0, '0,             11'd0,    4'd0,  1'b1, 2'd1},
    '{1'b0, '0,             11'd0,    4'd12, 1'b1, 2'd3},
    '{1'b0, '0,             11'd0,    4'd0,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd3,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd4,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd9,  1'b0, 2'd0},
    '{1'b1, REG_FRAME_ROWS, 11'd3,    4'd0,  1'b0, 2'd0},
    '{1'b1, REG_FRAME_COLS, 11'h7C3,  4'd0,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd9,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0},
    '{1'b0, '0,             11'd0,    4'd1,  1'b0, 2'd0}
  };

  filt_word_t typed_words [0:7] = '{
    '{10'd0, 5'd0, 4'd9, 7'd35, 1'b0, 1'b1},
    '{10'd0, 5'd1, 4'd0, 7'd32, 1'b0, 1'b0},
    '{10'd1, 5'd0, 4'd0, 7'd32, 1'b0, 1'b0},
    '{10'd1, 5'd1, 4'd9, 7'd35, 1'b1, 1'b1},
    '{10'd0, 5'd0, 4'd0, 7'd32, 1'b0, 1'b1},
    '{10'd0, 5'd1, 4'd9, 7'd35, 1'b0, 1'b0},
    '{10'd1, 5'd0, 4'd9, 7'd35, 1'b0, 1'b0},
    '{10'd1, 5'd1, 4'd0, 7'd32, 1'b1, 1'b1}
  };

  string glyph_set = " .':~*=&%#";

  // predictor state
  logic [PIX_W-1:0]      grid [0:2][0:DEF_MAX_COLS-1];
  logic [CFG_ROWS_W-1:0] frame_rows_q;
  logic [CFG_COLS_W-1:0] frame_cols_q;
  int unsigned           next_row;
  int unsigned           next_col;
  filt_word_t            step_res [0:2];
  int                    step_n;

  filt_word_t filtered_q [$];
  int typed_at;
  int errors;
  int pixels_sent;
  int words_seen;
  int settings_n;
  int kept_n;
  int swapped_n;
  bit calm;
  bit rx_stalls;
  int hold_left;
  int quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned span(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] filtered_level(int unsigned r, int unsigned c,
                                                      int unsigned rows, int unsigned cols);
    int unsigned v, cnt, sum, q, rem, d;
    int unsigned nb [4];
    v = grid[r % 3][c];
    cnt = 0;
    sum = 0;
    if (r > 0) begin
      nb[cnt] = grid[(r - 1) % 3][c];
      cnt++;
    end
    if (r + 1 < rows) begin
      nb[cnt] = grid[(r + 1) % 3][c];
      cnt++;
    end
    if (c > 0) begin
      nb[cnt] = grid[r % 3][c - 1];
      cnt++;
    end
    if (c + 1 < cols) begin
      nb[cnt] = grid[r % 3][c + 1];
      cnt++;
    end
    for (int i = 0; i < cnt; i++) begin
      d = (nb[i] > v) ? nb[i] - v : v - nb[i];
      if (d <= 1) return v[PIX_W-1:0];
      sum += nb[i];
    end
    q = sum / cnt;
    rem = sum % cnt;
    // round half to even
    if (2 * rem > cnt || (2 * rem == cnt && q[0])) q++;
    if (q > LEVEL_MAX) q = LEVEL_MAX;
    return q[PIX_W-1:0];
  endfunction

  task automatic add_word(input int unsigned r, c, rows, cols);
    filt_word_t w;
    logic [PIX_W-1:0] lv;
    byte g;
    lv = filtered_level(r, c, rows, cols);
    if (lv == grid[r % 3][c]) kept_n++;
    else swapped_n++;
    g = glyph_set[lv];
    w.row = r[ROW_W-1:0];
    w.col = c[COL_W-1:0];
    w.lvl = lv;
    w.gly = g[GLYPH_W-1:0];
    w.fend = (r + 1 == rows && c + 1 == cols);
    w.rend = 1'b0;
    step_res[step_n] = w;
    step_n++;
  endtask

  task automatic deglitch_step(input logic [PIX_W-1:0] raw);
    int unsigned rows, cols, r, c;
    rows = span(frame_rows_q, DEF_MAX_ROWS);
    cols = span(frame_cols_q, DEF_MAX_COLS);
    r = (next_row >= rows) ? 0 : next_row;
    c = (next_col >= cols) ? 0 : next_col;
    grid[r % 3][c] = (raw > LEVEL_MAX) ? LEVEL_MAX : raw;
    step_n = 0;
    if (r > 0) add_word(r - 1, c, rows, cols);
    if (r + 1 == rows) begin
      if (c > 0) add_word(r, c - 1, rows, cols);
      if (c + 1 == cols) add_word(r, c, rows, cols);
    end
    if (step_n > 0) step_res[step_n-1].rend = 1'b1;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  task automatic report(input string what, input int r, input int c, input int got_v,
                        input int want_v);
    if (errors < 40)
      $display("mismatch %s at row %0d col %0d: got %0d, want %0d", what, r, c, got_v, want_v);
    errors++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    if (idx == REG_FRAME_ROWS) begin
      frame_rows_q = d[CFG_ROWS_W-1:0];
      next_row = 0;
      next_col = 0;
    end else if (idx == REG_FRAME_COLS) begin
      frame_cols_q = d[CFG_COLS_W-1:0];
      next_row = 0;
      next_col = 0;
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // typed_n below zero takes the words from the predictor
  task automatic send_pixel(input logic [PIX_W-1:0] p, input bit gaps, input int typed_n);
    if (gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deglitch_step(p);
    pixels_sent++;
    if (pixels_sent >= CALM_FROM) calm = 1'b1;
    if (typed_n < 0) begin
      for (int k = 0; k < step_n; k++) filtered_q.push_back(step_res[k]);
    end else begin
      for (int k = 0; k < typed_n; k++) begin
        filtered_q.push_back(typed_words[typed_at]);
        typed_at++;
      end
    end
  endtask

  function automatic logic [PIX_W-1:0] next_level(logic [PIX_W-1:0] prev);
    int k, v;
    k = $urandom_range(0, 19);
    if (k < 11) begin
      // smooth area, mostly kept
      v = (prev > LEVEL_MAX) ? LEVEL_MAX : prev;
      v = v + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > LEVEL_MAX) v = LEVEL_MAX;
    end else if (k < 16) begin
      v = $urandom_range(0, 9);
    end else begin
      v = $urandom_range(0, 15);
    end
    return v[PIX_W-1:0];
  endfunction

  task automatic run_phase(input logic [CFG_DATA_W-1:0] rows_d,
                           input logic [CFG_DATA_W-1:0] cols_d, input int n);
    int split_at;
    bit gaps;
    logic [PIX_W-1:0] lv;
    drain_words();
    case ($urandom_range(0, 4)) inside
      0: write_reg(REG_FRAME_COLS, cols_d);
      1, 2: begin
        write_reg(REG_FRAME_ROWS, rows_d);
        write_reg(REG_FRAME_COLS, cols_d);
      end
      default: begin
        write_reg(REG_FRAME_COLS, cols_d);
        write_reg(REG_FRAME_ROWS, rows_d);
      end
    endcase
    cfg_we <= 1'b0;
    settings_n++;
    gaps = $urandom_range(0, 3) != 0;
    rx_stalls = $urandom_range(0, 3) != 0;
    split_at = ($urandom_range(0, 3) == 0) ? n / 2 : -1;
    lv = PIX_W'($urandom_range(0, 9));
    for (int i = 0; i < n; i++) begin
      if (i == split_at) begin
        // a write to a free index must leave the frame position alone
        drain_words();
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom_range(0, 2047)));
        cfg_we <= 1'b0;
      end
      lv = next_level(lv);
      send_pixel(lv, gaps, -1);
    end
  endtask

  // receiver side: random bursts with out_ready held low
  always @(posedge clk) begin
    if (rst || calm || !rx_stalls) begin
      out_ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (out_ready) begin
      if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(0, 15);
      end
    end else begin
      out_ready <= 1'b1;
      hold_left <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin : check_words
    filt_word_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {out_row, out_col, level, glyph, frame_end, run_end};
      words_seen++;
      if (filtered_q.size() == 0) begin
        report("word with nothing due", got.row, got.col, got.lvl, 0);
      end else begin
        want = filtered_q.pop_front();
        if (got.row != want.row) report("out_row", want.row, want.col, got.row, want.row);
        if (got.col != want.col) report("out_col", want.row, want.col, got.col, want.col);
        if (got.lvl != want.lvl) report("level", want.row, want.col, got.lvl, want.lvl);
        if (got.gly != want.gly) report("glyph", want.row, want.col, got.gly, want.gly);
        if (got.fend != want.fend)
          report("frame_end", want.row, want.col, got.fend, want.fend);
        if (got.rend != want.rend) report("run_end", want.row, want.col, got.rend, want.rend);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d words still due", filtered_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int eff_r, eff_c, n;
    logic [CFG_DATA_W-1:0] rows_d, cols_d;
    bit in_cfg;
    clk = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pixel <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FRAME_ROWS;
    cfg_data <= '0;
    foreach (grid[i, j]) grid[i][j] = '0;
    frame_rows_q = RESET_ROWS;
    frame_cols_q = RESET_COLS;
    next_row = 0;
    next_col = 0;
    calm = 1'b0;
    rx_stalls = 1'b1;
    typed_at = 0;
    errors = 0;
    pixels_sent = 0;
    words_seen = 0;
    settings_n = 0;
    kept_n = 0;
    swapped_n = 0;
    in_cfg = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].is_cfg) begin
        if (!in_cfg) drain_words();
        write_reg(script[i].idx, script[i].data);
        if (!in_cfg) settings_n++;
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send_pixel(script[i].px, 1'b1, script[i].typed ? int'(script[i].n_typed) : -1);
      end
    end

    // extremes first: widest two-row frame, tallest narrow frame, clamped maxima, clamped minima
    run_phase(11'd2, 11'd32, 64);
    run_phase(11'd1024, 11'd2, 60);
    run_phase(11'd2047, 11'h7FF, 48);
    run_phase(11'd1, 11'h7C0, 12);

    while (pixels_sent < TOTAL_PIXELS) begin
      case ($urandom_range(0, 11))
        0: rows_d = 11'd0;
        1: rows_d = 11'd1;
        2: rows_d = CFG_DATA_W'($urandom_range(1025, 2047));
        3: rows_d = 11'd1024;
        default: rows_d = CFG_DATA_W'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 11)) inside
        0: cols_d = 11'd0;
        1: cols_d = 11'd1;
        2: cols_d = CFG_DATA_W'($urandom_range(33, 63));
        3: cols_d = 11'd32;
        4, 5: cols_d = CFG_DATA_W'($urandom_range(13, 31));
        default: cols_d = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      // bits above the column field are don't-care
      cols_d[CFG_DATA_W-1:CFG_COLS_W] = (CFG_DATA_W - CFG_COLS_W)'($urandom_range(0, 31));
      eff_r = span(rows_d, DEF_MAX_ROWS);
      eff_c = span(cols_d[CFG_COLS_W-1:0], DEF_MAX_COLS);
      if (eff_r * eff_c <= 72)
        n = eff_r * eff_c * $urandom_range(1, 2) + $urandom_range(0, eff_c);
      else
        n = eff_c * $urandom_range(2, 3);
      if (n > TOTAL_PIXELS - pixels_sent) n = TOTAL_PIXELS - pixels_sent;
      run_phase(rows_d, cols_d, n);
    end

    drain_words();
    $display("%0d pixels over %0d frame settings, %0d filtered words checked",
             pixels_sent, settings_n, words_seen);
    $display("predicted levels: %0d kept, %0d replaced by neighbour mean", kept_n, swapped_n);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### impulse_deglitch_filter.f
rtl/core/idf_pkg.sv
rtl/core/idf_ctrl.sv
rtl/core/idf_datapath.sv
rtl/core/impulse_deglitch_filter.sv
sim/tb.sv
